/* hdl/sodsf_pkg.sv */
// shared types and constants of the send-on-delta store filter
package sodsf_pkg;

   localparam int TempWidth     = 16;
   localparam int PowerWidth    = 19;
   localparam int CsrDataWidth  = 19;
   localparam int CsrIndexWidth = 3;

   typedef enum logic [1:0] {
      MODE_ALWAYS    = 2'd0,
      MODE_THRESHOLD = 2'd1,
      MODE_DELTA     = 2'd2
   } mode_type;

   localparam logic [CsrIndexWidth-1:0] REG_STORAGE_MODE    = 3'd0;
   localparam logic [CsrIndexWidth-1:0] REG_COLD_PRESENT    = 3'd1;
   localparam logic [CsrIndexWidth-1:0] REG_HOT_PRESENT     = 3'd2;
   localparam logic [CsrIndexWidth-1:0] REG_POWER_PRESENT   = 3'd3;
   localparam logic [CsrIndexWidth-1:0] REG_TEMP_THRESHOLD  = 3'd4;
   localparam logic [CsrIndexWidth-1:0] REG_POWER_THRESHOLD = 3'd5;

   typedef struct packed {
      mode_type                mode;
      logic                    cold_present;
      logic                    hot_present;
      logic                    power_present;
      logic [TempWidth-1:0]    temp_threshold;
      logic [PowerWidth-1:0]   power_threshold;
   } cfg_type;

   typedef struct packed {
      logic signed [TempWidth-1:0] cold;
      logic signed [TempWidth-1:0] hot;
      logic [PowerWidth-1:0]       power;
   } point_type;

endpackage

/* hdl/sodsf_decide.sv */
// store decision of one measurement against the last stored point
module sodsf_decide (
   input  sodsf_pkg::cfg_type   cfg,
   input  sodsf_pkg::point_type sample,
   input  sodsf_pkg::point_type last,
   output logic                 store
);

   logic signed [sodsf_pkg::TempWidth:0] cold_diff;
   logic signed [sodsf_pkg::TempWidth:0] hot_diff;
   logic [sodsf_pkg::TempWidth:0]        cold_dist;
   logic [sodsf_pkg::TempWidth:0]        hot_dist;
   logic [sodsf_pkg::TempWidth:0]        temp_thr;
   logic [sodsf_pkg::PowerWidth-1:0]     power_dist;
   logic                                 power_above;
   logic                                 last_above;

   assign cold_diff = {sample.cold[sodsf_pkg::TempWidth-1], sample.cold}
                    - {last.cold[sodsf_pkg::TempWidth-1], last.cold};
   assign hot_diff  = {sample.hot[sodsf_pkg::TempWidth-1], sample.hot}
                    - {last.hot[sodsf_pkg::TempWidth-1], last.hot};

   assign cold_dist = cold_diff[sodsf_pkg::TempWidth] ? (sodsf_pkg::TempWidth+1)'(-cold_diff)
                                                      : (sodsf_pkg::TempWidth+1)'(cold_diff);
   assign hot_dist  = hot_diff[sodsf_pkg::TempWidth] ? (sodsf_pkg::TempWidth+1)'(-hot_diff)
                                                     : (sodsf_pkg::TempWidth+1)'(hot_diff);
   assign temp_thr  = {1'b0, cfg.temp_threshold};

   assign power_dist = (sample.power >= last.power) ? (sample.power - last.power)
                                                    : (last.power - sample.power);
   assign power_above = sample.power > cfg.power_threshold;
   assign last_above  = last.power > cfg.power_threshold;

   always_comb begin
      unique case (cfg.mode)
         sodsf_pkg::MODE_THRESHOLD: begin
            store = (cfg.cold_present && (cold_dist > temp_thr))
                 || (cfg.hot_present && (hot_dist > temp_thr))
                 || (cfg.power_present && (power_above != last_above));
         end
         sodsf_pkg::MODE_DELTA: begin
            store = (cfg.cold_present && (cold_dist >= temp_thr))
                 || (cfg.hot_present && (hot_dist >= temp_thr))
                 || (cfg.power_present && (power_dist >= cfg.power_threshold));
         end
         default: begin
            store = 1'b1;
         end
      endcase
   end

endmodule

/* hdl/send_on_delta_store_filter_unit.sv */
// Send-on-delta store filter: each measurement (cold temperature, hot temperature,
// power in tenths) is compared with the last stored point and the block reports
// whether it is stored; a stored measurement replaces the last point. An item
// goes from the input register through the decision into the result register;
// one item is taken every cycle unless req_stall holds it. The last point is
// updated in the same cycle its decision is made, so the next item sees it at
// once. Stall on the result side holds the result register and backs up into
// the input register before the input stalls. Configuration registers are
// written through csr_we/csr_index/csr_wdata, by the user only while the block
// is idle (the block does not enforce it); reset clears them and the last point to zero.
module send_on_delta_store_filter_unit (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_stall,
   input  logic signed [sodsf_pkg::TempWidth-1:0]  req_cold_temp,
   input  logic signed [sodsf_pkg::TempWidth-1:0]  req_hot_temp,
   input  logic [sodsf_pkg::PowerWidth-1:0]        req_power_level,
   output logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   output logic                                    rsp_store,
   input  logic                                    csr_we,
   input  logic [sodsf_pkg::CsrIndexWidth-1:0]     csr_index,
   input  logic [sodsf_pkg::CsrDataWidth-1:0]      csr_wdata
);

   sodsf_pkg::cfg_type   cfg_ff, cfg_in;
   sodsf_pkg::point_type s1_ff, s1_in;
   sodsf_pkg::point_type last_ff, last_in;
   logic                 s1_valid_ff, s1_valid_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_store_ff, rsp_store_in;
   logic                 rsp_load;
   logic                 s1_move;
   logic                 req_xfer;
   logic                 store;

   assign rsp_load  = !rsp_valid_ff || !rsp_stall;
   assign s1_move   = s1_valid_ff && rsp_load;
   assign req_stall = reset || (s1_valid_ff && !rsp_load);
   assign req_xfer  = req_valid && !req_stall;

   sodsf_decide u_decide (
      .cfg    (cfg_ff),
      .sample (s1_ff),
      .last   (last_ff),
      .store  (store)
   );

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            sodsf_pkg::REG_STORAGE_MODE:    cfg_in.mode = sodsf_pkg::mode_type'(csr_wdata[1:0]);
            sodsf_pkg::REG_COLD_PRESENT:    cfg_in.cold_present = csr_wdata[0];
            sodsf_pkg::REG_HOT_PRESENT:     cfg_in.hot_present = csr_wdata[0];
            sodsf_pkg::REG_POWER_PRESENT:   cfg_in.power_present = csr_wdata[0];
            sodsf_pkg::REG_TEMP_THRESHOLD:
               cfg_in.temp_threshold = csr_wdata[sodsf_pkg::TempWidth-1:0];
            sodsf_pkg::REG_POWER_THRESHOLD:
               cfg_in.power_threshold = csr_wdata[sodsf_pkg::PowerWidth-1:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      s1_valid_in  = req_xfer || (s1_valid_ff && !s1_move);
      s1_in        = s1_ff;
      if (req_xfer) begin
         s1_in.cold  = req_cold_temp;
         s1_in.hot   = req_hot_temp;
         s1_in.power = req_power_level;
      end
      rsp_valid_in = s1_move || (rsp_valid_ff && rsp_stall);
      rsp_store_in = s1_move ? store : rsp_store_ff;
      last_in      = (s1_move && store) ? s1_ff : last_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff       <= '0;
         last_ff      <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         last_ff      <= last_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_ff        <= s1_in;
      rsp_store_ff <= rsp_store_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_store = rsp_store_ff;

endmodule

/* hdl/sodsf_checker.sv */
// port-level checks of the store filter and their binding to the top level
module sodsf_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_stall,
   input logic rsp_valid,
   input logic rsp_stall,
   input logic rsp_store
);

   logic req_xfer;

   assign req_xfer = req_valid && !req_stall;

   // held result keeps its value
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_store))
      else $error("stalled result changed");

   // input only backs up behind a waiting result
   a_no_stall_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("input stalled with empty result register");

   // every input transfer is followed by a valid result
   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> ##1 rsp_valid)
      else $error("result missing after input transfer");

   // a fresh result comes from an input transfer through the input register
   a_no_invented: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_xfer, 2))
      else $error("result without input transfer");

endmodule

bind send_on_delta_store_filter_unit sodsf_checker u_sodsf_checker (.*);

/* tb/tb_top.sv */
// self-checking testbench of the send-on-delta store filter unit
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [1:0] MODE_UNUSED = 2'd3;
   localparam int HoldCycles  = 60;
   localparam int DrainCycles = 6;
   localparam int QuietLimit  = 2000;
   localparam int RandomItems = 150;

   logic                                   clock = 1'b0;
   logic                                   reset = 1'b1;
   logic                                   req_valid = 1'b0;
   logic                                   req_stall;
   logic signed [sodsf_pkg::TempWidth-1:0] req_cold_temp = '0;
   logic signed [sodsf_pkg::TempWidth-1:0] req_hot_temp = '0;
   logic [sodsf_pkg::PowerWidth-1:0]       req_power_level = '0;
   logic                                   rsp_valid;
   logic                                   rsp_stall = 1'b0;
   logic                                   rsp_store;
   logic                                   csr_we = 1'b0;
   logic [sodsf_pkg::CsrIndexWidth-1:0]    csr_index = '0;
   logic [sodsf_pkg::CsrDataWidth-1:0]     csr_wdata = '0;

   sodsf_pkg::point_type pending_points[$];
   bit                   expected_store[$];
   sodsf_pkg::cfg_type   filter_cfg = '0;
   sodsf_pkg::point_type last_stored = '0;
   sodsf_pkg::point_type recent_point = '0;
   int                   tx_idle_pct = 0;
   int                   rx_idle_pct = 0;
   bit                   hold_armed = 1'b0;
   int                   error_count = 0;

   send_on_delta_store_filter_unit DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_cold_temp   (req_cold_temp),
      .req_hot_temp    (req_hot_temp),
      .req_power_level (req_power_level),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_store       (rsp_store),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // decides whether a measurement is kept and updates the last stored point
   function automatic bit filter_point(sodsf_pkg::point_type p);
      int          cold_now, hot_now, cold_last, hot_last;
      int unsigned dcold, dhot, pw_now, pw_last, dpow, tlim, plim;
      bit          keep;
      cold_now  = int'(p.cold);
      hot_now   = int'(p.hot);
      cold_last = int'(last_stored.cold);
      hot_last  = int'(last_stored.hot);
      pw_now    = 32'(p.power);
      pw_last   = 32'(last_stored.power);
      tlim      = 32'(filter_cfg.temp_threshold);
      plim      = 32'(filter_cfg.power_threshold);
      dcold = (cold_now >= cold_last) ? cold_now - cold_last : cold_last - cold_now;
      dhot  = (hot_now >= hot_last) ? hot_now - hot_last : hot_last - hot_now;
      dpow  = (pw_now >= pw_last) ? pw_now - pw_last : pw_last - pw_now;
      keep  = 1'b0;
      case (filter_cfg.mode)
         sodsf_pkg::MODE_THRESHOLD: begin
            if (filter_cfg.cold_present && dcold > tlim) keep = 1'b1;
            if (filter_cfg.hot_present && dhot > tlim) keep = 1'b1;
            if (filter_cfg.power_present && ((pw_now > plim) != (pw_last > plim)))
               keep = 1'b1;
         end
         sodsf_pkg::MODE_DELTA: begin
            if (filter_cfg.cold_present && dcold >= tlim) keep = 1'b1;
            if (filter_cfg.hot_present && dhot >= tlim) keep = 1'b1;
            if (filter_cfg.power_present && dpow >= plim) keep = 1'b1;
         end
         default: keep = 1'b1;
      endcase
      if (keep) last_stored = p;
      return keep;
   endfunction

   // temperature move around the threshold, either sign
   function automatic logic [sodsf_pkg::TempWidth-1:0] temp_step();
      int lim, mag;
      lim = int'(filter_cfg.temp_threshold);
      case ($urandom_range(3))
         0: mag = lim;
         1: mag = lim + 1;
         2: mag = (lim == 0) ? 0 : lim - 1;
         default: mag = int'($urandom_range(lim + 2));
      endcase
      if ($urandom_range(1) == 1) mag = -mag;
      return mag[sodsf_pkg::TempWidth-1:0];
   endfunction

   function automatic sodsf_pkg::point_type next_point(sodsf_pkg::point_type prev);
      sodsf_pkg::point_type p;
      int                   pw, plim;
      plim = int'(filter_cfg.power_threshold);
      if ($urandom_range(99) < 20) begin
         p.cold  = (sodsf_pkg::TempWidth)'($urandom);
         p.hot   = (sodsf_pkg::TempWidth)'($urandom);
         p.power = (sodsf_pkg::PowerWidth)'($urandom);
         return p;
      end
      p.cold = ($urandom_range(3) == 0) ? prev.cold : prev.cold + temp_step();
      p.hot  = ($urandom_range(3) == 0) ? prev.hot : prev.hot + temp_step();
      if ($urandom_range(1) == 1) begin
         pw = plim + int'($urandom_range(8)) - 4;
      end else begin
         pw = plim + int'($urandom_range(2)) - 1;
         pw = ($urandom_range(1) == 1) ? int'(prev.power) + pw : int'(prev.power) - pw;
      end
      if (pw < 0) pw = 0;
      if (pw > (1 << sodsf_pkg::PowerWidth) - 1) pw = (1 << sodsf_pkg::PowerWidth) - 1;
      p.power = pw[sodsf_pkg::PowerWidth-1:0];
      return p;
   endfunction

   function automatic void queue_point(int cold, int hot, int power);
      recent_point.cold  = cold[sodsf_pkg::TempWidth-1:0];
      recent_point.hot   = hot[sodsf_pkg::TempWidth-1:0];
      recent_point.power = power[sodsf_pkg::PowerWidth-1:0];
      pending_points.push_back(recent_point);
   endfunction

   task automatic report_mismatch(string what, logic want, logic got);
      $display("%0t ns: %s: expected %0b, got %0b", $time, what, want, got);
      error_count++;
   endtask

   task automatic wait_drained();
      do
         @(negedge clock);
      while (pending_points.size() != 0 || req_valid || expected_store.size() != 0);
   endtask

   task automatic settle();
      wait_drained();
      repeat (DrainCycles) @(negedge clock);
   endtask

   task automatic write_csr(logic [sodsf_pkg::CsrIndexWidth-1:0] index,
                            logic [sodsf_pkg::CsrDataWidth-1:0] data);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      case (index)
         sodsf_pkg::REG_STORAGE_MODE:
            filter_cfg.mode = sodsf_pkg::mode_type'(data[1:0]);
         sodsf_pkg::REG_COLD_PRESENT:  filter_cfg.cold_present = data[0];
         sodsf_pkg::REG_HOT_PRESENT:   filter_cfg.hot_present = data[0];
         sodsf_pkg::REG_POWER_PRESENT: filter_cfg.power_present = data[0];
         sodsf_pkg::REG_TEMP_THRESHOLD:
            filter_cfg.temp_threshold = data[sodsf_pkg::TempWidth-1:0];
         sodsf_pkg::REG_POWER_THRESHOLD:
            filter_cfg.power_threshold = data[sodsf_pkg::PowerWidth-1:0];
         default: ;
      endcase
   endtask

   task automatic apply_setting(logic [1:0] mode, bit cold_on, bit hot_on, bit power_on,
                                int unsigned temp_lim, int unsigned power_lim);
      write_csr(sodsf_pkg::REG_STORAGE_MODE, (sodsf_pkg::CsrDataWidth)'(mode));
      write_csr(sodsf_pkg::REG_COLD_PRESENT, (sodsf_pkg::CsrDataWidth)'(cold_on));
      write_csr(sodsf_pkg::REG_HOT_PRESENT, (sodsf_pkg::CsrDataWidth)'(hot_on));
      write_csr(sodsf_pkg::REG_POWER_PRESENT, (sodsf_pkg::CsrDataWidth)'(power_on));
      write_csr(sodsf_pkg::REG_TEMP_THRESHOLD, (sodsf_pkg::CsrDataWidth)'(temp_lim));
      write_csr(sodsf_pkg::REG_POWER_THRESHOLD, (sodsf_pkg::CsrDataWidth)'(power_lim));
      @(posedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   task automatic run_phase(int count);
      int left, burst;
      left = count;
      while (left > 0) begin
         burst = $urandom_range(80, 20);
         if (burst > left) burst = left;
         repeat (burst) begin
            recent_point = next_point(recent_point);
            pending_points.push_back(recent_point);
         end
         left -= burst;
         wait_drained();
      end
   endtask

   always @(posedge clock) begin : measurement_driver
      sodsf_pkg::point_type p;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            p.cold  = req_cold_temp;
            p.hot   = req_hot_temp;
            p.power = req_power_level;
            expected_store.push_back(filter_point(p));
         end
         if (!req_valid || !req_stall) begin
            if (pending_points.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
               p = pending_points.pop_front();
               req_valid       <= 1'b1;
               req_cold_temp   <= p.cold;
               req_hot_temp    <= p.hot;
               req_power_level <= p.power;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : result_monitor
      bit want;
      int hold_left;
      bit hold_taken;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_store.size() == 0) begin
               report_mismatch("result transfer with nothing pending", 1'b0, rsp_store);
            end else begin
               want = expected_store.pop_front();
               if (rsp_store !== want) report_mismatch("store", want, rsp_store);
            end
         end
         // long hold-off so the pipeline fills and backs up into the input
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else if (hold_armed && !hold_taken) begin
            hold_taken = 1'b1;
            hold_left  = HoldCycles;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99) < rx_idle_pct);
         end
      end
   end

   always @(posedge clock) begin : watchdog
      int quiet_cycles;
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= QuietLimit) begin
            $display("send_on_delta_store_filter_unit: mismatch");
            $finish;
         end
      end
   end

   initial begin : stimulus
      logic [1:0]  mode;
      int unsigned temp_lim, power_lim;
      bit          all_on;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);
      tx_idle_pct = 30;
      rx_idle_pct = 55;

      // reset settings keep every measurement; field extremes
      queue_point(32767, -32768, 0);
      queue_point(0, 0, 524287);
      queue_point(-32768, -32768, 300000);
      settle();
      // full-scale temperature swing equal to the threshold
      apply_setting(sodsf_pkg::MODE_THRESHOLD, 1, 1, 1, 65535, 524287);
      queue_point(32767, 32767, 524287);
      settle();
      apply_setting(sodsf_pkg::MODE_DELTA, 1, 1, 0, 65535, 524287);
      queue_point(32767, 32767, 0);
      queue_point(32766, 32767, 0);
      settle();
      // power crossing its threshold, including beyond the nominal range
      apply_setting(sodsf_pkg::MODE_THRESHOLD, 0, 0, 1, 0, 300000);
      queue_point(0, 0, 300000);
      queue_point(0, 0, 300001);
      queue_point(9, 9, 400000);
      queue_point(0, 0, 0);
      settle();
      // no source considered
      apply_setting(sodsf_pkg::MODE_DELTA, 0, 0, 0, 0, 0);
      queue_point(1, 2, 3);
      queue_point(-5, 7, 11);
      settle();
      apply_setting(MODE_UNUSED, 0, 0, 0, 0, 0);
      queue_point(100, -100, 7);
      settle();
      apply_setting(sodsf_pkg::MODE_THRESHOLD, 1, 0, 0, 0, 0);
      queue_point(100, 5, 9);
      queue_point(101, 5, 9);
      settle();
      apply_setting(sodsf_pkg::MODE_DELTA, 0, 1, 1, 10, 1000);
      queue_point(101, 15, 9);
      queue_point(101, 24, 1008);
      queue_point(101, 24, 1009);

      for (int phase = 0; phase < 10; phase++) begin
         if (phase == 4) begin
            tx_idle_pct = 55;
            rx_idle_pct = 30;
         end
         if (phase == 7) begin
            tx_idle_pct = 0;
            rx_idle_pct = 0;
         end
         case (phase)
            4: mode = sodsf_pkg::MODE_ALWAYS;
            7: mode = MODE_UNUSED;
            default: mode = (phase % 2 == 0) ? sodsf_pkg::MODE_THRESHOLD
                                             : sodsf_pkg::MODE_DELTA;
         endcase
         case (phase)
            0: temp_lim = 0;
            1, 2: temp_lim = 65535;
            default: temp_lim = ($urandom_range(3) == 0) ? $urandom_range(65535)
                                                        : $urandom_range(300);
         endcase
         case (phase)
            0: power_lim = 0;
            3: power_lim = 524287;
            5: power_lim = 300000;
            default: power_lim = ($urandom_range(3) == 0) ? $urandom_range(524287)
                                                         : $urandom_range(3000);
         endcase
         all_on = (phase < 2);
         settle();
         apply_setting(mode, all_on | 1'($urandom_range(1)), all_on | 1'($urandom_range(1)),
                       all_on | 1'($urandom_range(1)), temp_lim, power_lim);
         if (phase == 8) hold_armed = 1'b1;
         run_phase(RandomItems);
      end

      wait_drained();
      repeat (DrainCycles) @(negedge clock);
      if (expected_store.size() != 0)
         report_mismatch("result never arrived", expected_store[0], 1'bx);
      if (error_count == 0) begin
         $display("send_on_delta_store_filter_unit: match");
      end else begin
         $display("send_on_delta_store_filter_unit: mismatch");
      end
      $finish;
   end

endmodule

/* send_on_delta_store_filter_unit.f */
hdl/sodsf_pkg.sv
hdl/sodsf_decide.sv
hdl/send_on_delta_store_filter_unit.sv
hdl/sodsf_checker.sv
tb/tb_top.sv
